// ===== design/icms_pkg.sv =====
// Shared constants, payload types and control structs for the inversion-counting merge sorter.
package icms_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int VAL_W        = 32;
    localparam int INV_W        = 11;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last_in;
    } t_in_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic [INV_W-1:0]        inversions;
        logic                    last_out;
    } t_out_req;

    typedef struct packed {
        logic                    we;
        logic [IDX_W-1:0]        waddr;
        logic signed [VAL_W-1:0] wdata;
        logic [IDX_W-1:0]        raddr_a;
        logic [IDX_W-1:0]        raddr_b;
    } t_bank_cmd;

    typedef struct packed {
        logic             done;
        logic             bank;
        logic [INV_W-1:0] total;
    } t_mrg_stat;

endpackage

// ===== design/inversion_count_merge_sort.sv =====
// Top level of the merge sorter that counts inversion pairs while sorting.
//
// Channel | Direction | Handshake             | Payload
// in      | input     | i_in_valid/o_in_ready | i_in (value, last_in)
// out     | output    | o_out_valid/i_out_ready | o_out (sorted_value, inversions, last_out)
//
// Loading accepts one element per cycle; a set closes on last_in or at 64 elements.
// Sorting runs ceil(log2 n) passes: a setup state per merged segment, a read and a
// compare state per element, and a finishing state, bounded by the compare unit and
// the bank reads. Emitting uses an address and a data state per element. Reset is
// synchronous and clears state, load count and output valid; banks are not cleared.
// A stalled output holds its register; loading of the next set may start meanwhile.
module inversion_count_merge_sort (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  icms_pkg::t_in_req  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output icms_pkg::t_out_req o_out
);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_SORT  = 4'b0010,
        S_EADDR = 4'b0100,
        S_EDATA = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [icms_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [icms_pkg::CNT_W-1:0]      r_n, n_n;
    logic [icms_pkg::CNT_W-1:0]      r_e, n_e;
    logic                            r_sbank, n_sbank;
    logic [icms_pkg::INV_W-1:0]      r_total, n_total;
    logic                            r_ov, n_ov;
    icms_pkg::t_out_req              r_out, n_out;

    logic                            in_acc, close, can_load, start;
    logic [icms_pkg::CNT_W-1:0]      cnt_next, e_next;
    icms_pkg::t_bank_cmd             cmd0, cmd1, mcmd0, mcmd1;
    icms_pkg::t_mrg_stat             mstat;
    logic signed [icms_pkg::VAL_W-1:0] rd_a0, rd_b0, rd_a1, rd_b1, edata;

    assign o_in_ready  = (r_state == S_LOAD);
    assign in_acc      = i_in_valid && o_in_ready;
    assign cnt_next    = r_cnt + 1'b1;
    assign close       = i_in.last_in ||
                         (cnt_next == icms_pkg::CNT_W'(icms_pkg::MAX_ELEMENTS));
    assign start       = in_acc && close;
    assign can_load    = !r_ov || i_out_ready;
    assign e_next      = r_e + 1'b1;
    assign edata       = r_sbank ? rd_a1 : rd_a0;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    always_comb begin
        cmd0         = '0;
        cmd1         = '0;
        cmd0.raddr_a = r_e[icms_pkg::IDX_W-1:0];
        cmd1.raddr_a = r_e[icms_pkg::IDX_W-1:0];
        unique case (r_state)
            S_LOAD: begin
                cmd0.we    = in_acc;
                cmd0.waddr = r_cnt[icms_pkg::IDX_W-1:0];
                cmd0.wdata = i_in.value;
            end
            S_SORT: begin
                cmd0 = mcmd0;
                cmd1 = mcmd1;
            end
            default: begin
                cmd0.we = 1'b0;
            end
        endcase
    end

    icms_bank u_bank0 (
        .i_clk  (i_clk),
        .i_cmd  (cmd0),
        .o_rd_a (rd_a0),
        .o_rd_b (rd_b0)
    );

    icms_bank u_bank1 (
        .i_clk  (i_clk),
        .i_cmd  (cmd1),
        .o_rd_a (rd_a1),
        .o_rd_b (rd_b1)
    );

    icms_merge_seq u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_count (cnt_next),
        .i_rd_a0 (rd_a0),
        .i_rd_b0 (rd_b0),
        .i_rd_a1 (rd_a1),
        .i_rd_b1 (rd_b1),
        .o_cmd0  (mcmd0),
        .o_cmd1  (mcmd1),
        .o_stat  (mstat)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_e     = r_e;
        n_sbank = r_sbank;
        n_total = r_total;
        n_ov    = r_ov;
        n_out   = r_out;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    n_cnt = cnt_next;
                    if (close) begin
                        n_n     = cnt_next;
                        n_cnt   = '0;
                        n_state = S_SORT;
                    end
                end
            end
            S_SORT: begin
                if (mstat.done) begin
                    n_sbank = mstat.bank;
                    n_total = mstat.total;
                    n_e     = '0;
                    n_state = S_EADDR;
                end
            end
            S_EADDR: begin
                n_state = S_EDATA;
            end
            S_EDATA: begin
                if (can_load) begin
                    n_ov               = 1'b1;
                    n_out.sorted_value = edata;
                    n_out.inversions   = r_total;
                    n_out.last_out     = (e_next == r_n);
                    n_e                = e_next;
                    n_state            = (e_next == r_n) ? S_LOAD : S_EADDR;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
        r_n     <= n_n;
        r_e     <= n_e;
        r_sbank <= n_sbank;
        r_total <= n_total;
        r_out   <= n_out;
    end

endmodule

// ===== design/icms_bank.sv =====
// Element bank with one write port and two registered read ports.
module icms_bank (
    input  logic                                     i_clk,
    input  icms_pkg::t_bank_cmd                      i_cmd,
    output logic signed [icms_pkg::VAL_W-1:0]        o_rd_a,
    output logic signed [icms_pkg::VAL_W-1:0]        o_rd_b
);

    logic signed [icms_pkg::VAL_W-1:0] r_mem [icms_pkg::MAX_ELEMENTS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        o_rd_a <= r_mem[i_cmd.raddr_a];
        o_rd_b <= r_mem[i_cmd.raddr_b];
    end

endmodule

// ===== design/icms_merge_seq.sv =====
// Bottom-up merge sequencer with a shared compare unit and inversion counter.
module icms_merge_seq (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [icms_pkg::CNT_W-1:0]           i_count,
    input  logic signed [icms_pkg::VAL_W-1:0]    i_rd_a0,
    input  logic signed [icms_pkg::VAL_W-1:0]    i_rd_b0,
    input  logic signed [icms_pkg::VAL_W-1:0]    i_rd_a1,
    input  logic signed [icms_pkg::VAL_W-1:0]    i_rd_b1,
    output icms_pkg::t_bank_cmd                  o_cmd0,
    output icms_pkg::t_bank_cmd                  o_cmd1,
    output icms_pkg::t_mrg_stat                  o_stat
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_SEG  = 5'b00010,
        M_RD   = 5'b00100,
        M_CMP  = 5'b01000,
        M_FIN  = 5'b10000
    } t_mstate;

    t_mstate                         r_state, n_state;
    logic [icms_pkg::CNT_W-1:0]      r_n, n_n;
    logic [icms_pkg::CNT_W-1:0]      r_w, n_w;
    logic [icms_pkg::CNT_W-1:0]      r_k, n_k;
    logic [icms_pkg::CNT_W-1:0]      r_i, n_i;
    logic [icms_pkg::CNT_W-1:0]      r_j, n_j;
    logic [icms_pkg::CNT_W-1:0]      r_mid, n_mid;
    logic [icms_pkg::CNT_W-1:0]      r_hi, n_hi;
    logic                            r_src, n_src;
    logic [icms_pkg::INV_W-1:0]      r_total, n_total;

    logic [icms_pkg::CNT_W:0]        mid_full, hi_full, n_ext;
    logic signed [icms_pkg::VAL_W-1:0] da, db;
    logic                            i_exh, j_exh, gt, take_j;
    logic [icms_pkg::CNT_W-1:0]      k_next, w_next;
    icms_pkg::t_bank_cmd             rd_cmd, wr_cmd;

    assign n_ext    = {1'b0, r_n};
    assign mid_full = {1'b0, r_k} + {1'b0, r_w};
    assign hi_full  = mid_full + {1'b0, r_w};
    assign da       = r_src ? i_rd_a1 : i_rd_a0;
    assign db       = r_src ? i_rd_b1 : i_rd_b0;
    assign i_exh    = (r_i == r_mid);
    assign j_exh    = (r_j == r_hi);
    assign gt       = da > db;
    assign take_j   = i_exh || (!j_exh && gt);
    assign k_next   = r_k + 1'b1;
    assign w_next   = r_w << 1;

    always_comb begin
        rd_cmd         = '0;
        rd_cmd.raddr_a = r_i[icms_pkg::IDX_W-1:0];
        rd_cmd.raddr_b = r_j[icms_pkg::IDX_W-1:0];
        wr_cmd         = '0;
        wr_cmd.we      = (r_state == M_CMP);
        wr_cmd.waddr   = r_k[icms_pkg::IDX_W-1:0];
        wr_cmd.wdata   = take_j ? db : da;
        o_cmd0         = r_src ? wr_cmd : rd_cmd;
        o_cmd1         = r_src ? rd_cmd : wr_cmd;
    end

    assign o_stat.done  = (r_state == M_FIN);
    assign o_stat.bank  = r_src;
    assign o_stat.total = r_total;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_w     = r_w;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_src   = r_src;
        n_total = r_total;
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_n     = i_count;
                    n_w     = {{(icms_pkg::CNT_W-1){1'b0}}, 1'b1};
                    n_k     = '0;
                    n_src   = 1'b0;
                    n_total = '0;
                    n_state = (i_count > {{(icms_pkg::CNT_W-1){1'b0}}, 1'b1}) ? M_SEG : M_FIN;
                end
            end
            M_SEG: begin
                n_i     = r_k;
                n_mid   = (mid_full > n_ext) ? r_n : mid_full[icms_pkg::CNT_W-1:0];
                n_j     = n_mid;
                n_hi    = (hi_full > n_ext) ? r_n : hi_full[icms_pkg::CNT_W-1:0];
                n_state = M_RD;
            end
            M_RD: begin
                n_state = M_CMP;
            end
            M_CMP: begin
                if (take_j) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
                if (!i_exh && !j_exh && gt) begin
                    n_total = r_total + {{(icms_pkg::INV_W-icms_pkg::CNT_W){1'b0}}, r_mid - r_i};
                end
                n_k = k_next;
                if (k_next == r_hi) begin
                    if (k_next == r_n) begin
                        n_k     = '0;
                        n_w     = w_next;
                        n_src   = !r_src;
                        n_state = (w_next < r_n) ? M_SEG : M_FIN;
                    end else begin
                        n_state = M_SEG;
                    end
                end else begin
                    n_state = M_RD;
                end
            end
            M_FIN: begin
                n_state = M_IDLE;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_src   <= 1'b0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
            r_total <= n_total;
        end
        r_n   <= n_n;
        r_w   <= n_w;
        r_k   <= n_k;
        r_i   <= n_i;
        r_j   <= n_j;
        r_mid <= n_mid;
        r_hi  <= n_hi;
    end

endmodule

// ===== design/icms_checker.sv =====
// Port-level checker for the merge sorter and its bind to the top level.
module icms_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input icms_pkg::t_in_req  i_in,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input icms_pkg::t_out_req i_out
);

    // A stalled result holds its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("output request changed while stalled");

    // The block stops taking requests once a set is closed by last_in.
    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in.last_in |=> !i_in_ready)
        else $error("input accepted right after a closing request");

    // No result is shown directly after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind inversion_count_merge_sort icms_checker u_icms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in        (i_in),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);
